// File: src/b2b_pkg.sv
// ---------------------------------------------------------------------------
// b2b_pkg
// types, constants and tables shared by the hash engine modules
// ---------------------------------------------------------------------------
package b2b_pkg;

  localparam int unsigned ROUNDS_DEF = 12;
  localparam int unsigned ROUNDS_MAX = 12;
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // request from the engine to the shared mixing unit
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] y;
  } g_in_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } g_out_t;

  function automatic logic [63:0] iv(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  // message schedule, row r and slot s
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    case (r)
      4'd0: row = 64'hfedcba9876543210;
      4'd1: row = 64'h357b20c16df984ae;
      4'd2: row = 64'h491763eadf250c8b;
      4'd3: row = 64'h8f04a562ebcd1397;
      4'd4: row = 64'hd386cb1efa427509;
      4'd5: row = 64'h91ef57d438b0a6c2;
      4'd6: row = 64'hb8293670a4def15c;
      4'd7: row = 64'ha2684f05931ce7bd;
      4'd8: row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[s*4 +: 4];
  endfunction

endpackage

// File: src/b2b_g.sv
// ---------------------------------------------------------------------------
// b2b_g
// one g mixing function, registered result
// ---------------------------------------------------------------------------
module b2b_g (
  input  logic          clk,
  input  b2b_pkg::g_in_t  g_in,
  output b2b_pkg::g_out_t g_out
);
  import b2b_pkg::*;

  logic [63:0] a1, d1, c1, b1, a2, d2, c2, b2;

  always_comb begin
    a1 = g_in.a + g_in.b + g_in.x;
    d1 = g_in.d ^ a1;
    d1 = {d1[31:0], d1[63:32]};
    c1 = g_in.c + d1;
    b1 = g_in.b ^ c1;
    b1 = {b1[23:0], b1[63:24]};
    a2 = a1 + b1 + g_in.y;
    d2 = d1 ^ a2;
    d2 = {d2[15:0], d2[63:16]};
    c2 = c1 + d2;
    b2 = b1 ^ c2;
    b2 = {b2[62:0], b2[63]};
  end

  always_ff @(posedge clk) begin
    g_out <= '{a: a2, b: b2, c: c2, d: d2};
  end
endmodule

// File: src/blake2b_hash.sv
// ---------------------------------------------------------------------------
// blake2b_hash
// unkeyed blake2b, 1..64 byte digest, one shared g unit under a sequencer
// ---------------------------------------------------------------------------
// sequence: a word is taken in S_IDLE and its valid bytes are written one per
//   step in S_LOAD while the input stays stalled; a byte that overflows a full
//   block first runs a compression of 8 g per round for ROUNDS rounds
// a last word adds the final compression, then S_OUT gives the digest words
// in order, held while out_stall is high; each g is issued in S_ISSUE and written back in S_WB
// reset (sync, rst high): length 64, empty message; config writes restart
// ---------------------------------------------------------------------------
module blake2b_hash #(
  parameter int unsigned ROUNDS = b2b_pkg::ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b2b_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b2b_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [b2b_pkg::LEN_W-1:0] cfg_data
);
  import b2b_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WB   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam int unsigned RW = $clog2(ROUNDS_MAX + 1);

  state_t        state;
  logic [LEN_W-1:0] dlen;
  logic [63:0]   h [8];
  logic [63:0]   v [16];
  logic [63:0]   m [16];
  logic [127:0]  cnt;
  logic [7:0]    fill;
  logic [3:0]    nb_left;
  logic [63:0]   pend_data;
  logic          pend_last;
  logic          fin;
  logic [RW-1:0] rnd;
  logic [2:0]    gi;
  logic [3:0]    ow;
  logic [3:0]    rrow;

  logic [6:0]    elen;
  logic [3:0]    nwords;
  logic [3:0]    ia, ib, ic, id;
  g_in_t         gin;
  g_out_t        gout;
  logic [2:0]    rem;
  logic [63:0]   mask;

  always_comb begin
    if (dlen == '0) elen = 7'd1;
    else if (dlen > 7'd64) elen = 7'd64;
    else elen = dlen;
    nwords = 4'((elen + 7'd7) >> 3);
  end

  // lane indices of the current g
  always_comb begin
    ia = {2'b00, gi[1:0]};
    if (!gi[2]) begin
      ib = 4'd4 + {2'b00, gi[1:0]};
      ic = 4'd8 + {2'b00, gi[1:0]};
      id = 4'd12 + {2'b00, gi[1:0]};
    end else begin
      ib = 4'd4 + {2'b00, 2'(gi[1:0] + 2'd1)};
      ic = 4'd8 + {2'b00, 2'(gi[1:0] + 2'd2)};
      id = 4'd12 + {2'b00, 2'(gi[1:0] + 2'd3)};
    end
    rrow = (rnd >= RW'(10)) ? 4'(rnd - RW'(10)) : 4'(rnd);
    gin.a = v[ia];
    gin.b = v[ib];
    gin.c = v[ic];
    gin.d = v[id];
    gin.x = m[sigma(rrow, {gi, 1'b0})];
    gin.y = m[sigma(rrow, {gi, 1'b1})];
  end

  b2b_g u_g (.clk(clk), .g_in(gin), .g_out(gout));

  always_comb begin
    rem = 3'(elen - {ow, 3'b000});
    mask = '1;
    if ((ow == nwords - 4'd1) && (rem != 3'd0)) mask = (64'd1 << {rem, 3'b000}) - 64'd1;
  end

  // a config transfer goes first; the input is stalled while cfg_valid is high
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data.digest_word = h[ow[2:0]] & mask;
  assign out_data.digest_last = (ow == nwords - 4'd1);

  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready)) begin
      state <= S_IDLE;
      if (rst) dlen <= LEN_RESET;
      else dlen <= cfg_data;
      for (int i = 1; i < 8; i++) h[i] <= iv(3'(i));
      h[0] <= iv(3'd0) ^ 64'h01010000 ^ {57'd0,
              (rst ? LEN_RESET : ((cfg_data == '0) ? 7'd1 :
              (cfg_data > 7'd64) ? 7'd64 : cfg_data))};
      for (int i = 0; i < 16; i++) m[i] <= '0;
      cnt <= '0;
      fill <= '0;
      ow <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_data <= in_data.data_word;
            pend_last <= in_data.is_last;
            nb_left <= (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (nb_left != 4'd0 && fill == 8'd128) begin
            cnt <= cnt + 128'd128;
            fin <= 1'b0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            for (int i = 0; i < 4; i++) v[i+8] <= iv(3'(i));
            v[12] <= iv(3'd4) ^ 64'(cnt + 128'd128);
            v[13] <= iv(3'd5) ^ 64'((cnt + 128'd128) >> 64);
            v[14] <= iv(3'd6);
            v[15] <= iv(3'd7);
            rnd <= '0;
            gi <= '0;
            state <= S_ISSUE;
          end else if (nb_left != 4'd0) begin
            m[fill[6:3]][fill[2:0]*8 +: 8] <= pend_data[7:0];
            pend_data <= pend_data >> 8;
            fill <= fill + 8'd1;
            nb_left <= nb_left - 4'd1;
          end else if (pend_last) begin
            cnt <= cnt + {120'd0, fill};
            fin <= 1'b1;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            for (int i = 0; i < 4; i++) v[i+8] <= iv(3'(i));
            v[12] <= iv(3'd4) ^ 64'(cnt + {120'd0, fill});
            v[13] <= iv(3'd5) ^ 64'((cnt + {120'd0, fill}) >> 64);
            v[14] <= ~iv(3'd6);
            v[15] <= iv(3'd7);
            rnd <= '0;
            gi <= '0;
            state <= S_ISSUE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ISSUE: state <= S_WB;
        S_WB: begin
          v[ia] <= gout.a;
          v[ib] <= gout.b;
          v[ic] <= gout.c;
          v[id] <= gout.d;
          gi <= gi + 3'd1;
          if (gi == 3'd7) rnd <= rnd + RW'(1);
          if (gi == 3'd7 && rnd == RW'(ROUNDS - 1)) begin
            // lanes written at this edge are folded in from the g result
            for (int i = 0; i < 8; i++) begin
              h[i] <= h[i] ^ v[i] ^ v[i+8] ^
                      ((i == int'(ia)) ? gout.a ^ v[ia] : 64'd0) ^
                      ((i == int'(ib)) ? gout.b ^ v[ib] : 64'd0) ^
                      ((i + 8 == int'(ic)) ? gout.c ^ v[ic] : 64'd0) ^
                      ((i + 8 == int'(id)) ? gout.d ^ v[id] : 64'd0);
            end
            if (fin) begin
              ow <= '0;
              state <= S_OUT;
            end else begin
              for (int i = 0; i < 16; i++) m[i] <= '0;
              fill <= '0;
              state <= S_LOAD;
            end
          end else begin
            state <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (ow == nwords - 4'd1) begin
              state <= S_IDLE;
              for (int i = 1; i < 8; i++) h[i] <= iv(3'(i));
              h[0] <= iv(3'd0) ^ 64'h01010000 ^ {57'd0, elen};
              for (int i = 0; i < 16; i++) m[i] <= '0;
              cnt <= '0;
              fill <= '0;
              ow <= '0;
            end else begin
              ow <= ow + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while digest pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("digest dropped");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= 8'd128) else $error("fill overflow");
endmodule

// File: test/blake2b_hash_test.sv
// ---------------------------------------------------------------------------
// blake2b_hash_test
// self-checking bench: directed messages from a table, then random messages,
// digests predicted by an in-bench blake2b model and compared word by word
// ---------------------------------------------------------------------------
module blake2b_hash_test;
  import b2b_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  blake2b_hash u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  localparam logic [63:0] FINAL_MASK = ~64'd0;

  // hash state of the predictor
  logic [6:0]   len_reg;
  logic [63:0]  chain [8];
  logic [127:0] nbytes_done;
  logic [63:0]  blk [16];
  int unsigned  fill;
  logic [63:0]  wv [16];

  out_item_t digest_q [$];
  int errors = 0;
  int mismatches = 0;
  bit quiet = 1'b0;

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic int unsigned hash_len();
    if (len_reg == 0) return 1;
    if (len_reg > 64) return 64;
    return len_reg;
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain[i] = iv(i[2:0]);
    chain[0] ^= 64'h01010000 ^ 64'(hash_len());
    nbytes_done = '0;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
  endfunction

  function automatic void g_mix(input int a, input int b, input int c, input int d,
                                input logic [63:0] x, input logic [63:0] y);
    wv[a] = wv[a] + wv[b] + x; wv[d] = ror(wv[d] ^ wv[a], 32);
    wv[c] = wv[c] + wv[d];     wv[b] = ror(wv[b] ^ wv[c], 24);
    wv[a] = wv[a] + wv[b] + y; wv[d] = ror(wv[d] ^ wv[a], 16);
    wv[c] = wv[c] + wv[d];     wv[b] = ror(wv[b] ^ wv[c], 63);
  endfunction

  function automatic void compress_block(input bit is_final);
    logic [3:0] s [16];
    for (int i = 0; i < 8; i++) begin
      wv[i] = chain[i];
      wv[i+8] = iv(i[2:0]);
    end
    wv[12] ^= nbytes_done[63:0];
    wv[13] ^= nbytes_done[127:64];
    if (is_final) wv[14] ^= FINAL_MASK;
    for (int r = 0; r < 12; r++) begin
      for (int k = 0; k < 16; k++) s[k] = sigma(4'(r % 10), 4'(k));
      g_mix(0, 4, 8, 12, blk[s[0]], blk[s[1]]);
      g_mix(1, 5, 9, 13, blk[s[2]], blk[s[3]]);
      g_mix(2, 6, 10, 14, blk[s[4]], blk[s[5]]);
      g_mix(3, 7, 11, 15, blk[s[6]], blk[s[7]]);
      g_mix(0, 5, 10, 15, blk[s[8]], blk[s[9]]);
      g_mix(1, 6, 11, 12, blk[s[10]], blk[s[11]]);
      g_mix(2, 7, 8, 13, blk[s[12]], blk[s[13]]);
      g_mix(3, 4, 9, 14, blk[s[14]], blk[s[15]]);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= wv[i] ^ wv[i+8];
  endfunction

  // absorbs one word; on the last word queues the digest words
  function automatic void absorb_word(input in_item_t it);
    int unsigned n, len, words, rem;
    logic [63:0] v;
    out_item_t o;
    n = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
    for (int k = 0; k < n; k++) begin
      if (fill >= 128) begin
        nbytes_done += 128;
        compress_block(1'b0);
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill = 0;
      end
      blk[fill/8][(fill%8)*8 +: 8] = it.data_word[k*8 +: 8];
      fill++;
    end
    if (!it.is_last) return;
    nbytes_done += 128'(fill);
    compress_block(1'b1);
    len = hash_len();
    words = (len + 7) / 8;
    for (int k = 0; k < words; k++) begin
      v = chain[k];
      rem = len - 8*k;
      if (rem < 8) v &= (64'd1 << (8*rem)) - 1;
      o.digest_word = v;
      o.digest_last = (k + 1 == words);
      digest_q.push_back(o);
    end
    restart_hash();
  endfunction

  task automatic wait_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  // valid stays up after a transfer until the next word or an idle gap
  task automatic send_word(input in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      wait_cycles($urandom_range(1, 9));
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    absorb_word(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  // engine must be idle; the tail wait covers a compression still in flight
  task automatic write_len(input logic [LEN_W-1:0] v);
    drain();
    wait_cycles(400);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    len_reg = v;
    restart_hash();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int nwords, input bit odd_counts);
    in_item_t it;
    for (int i = 0; i < nwords; i++) begin
      it.data_word = {$urandom, $urandom};
      it.valid_bytes = odd_counts ? 4'($urandom_range(0, 15)) : 4'd8;
      it.is_last = (i == nwords - 1);
      send_word(it);
    end
  endtask

  // receiver: random stall bursts, checks each transfer against the queue
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected digest word %h", out_data.digest_word);
      end else begin
        want = digest_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("digest mismatch: exp %h/%b got %h/%b", want.digest_word,
                     want.digest_last, out_data.digest_word, out_data.digest_last);
        end
      end
    end
  end

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (quiet) out_stall <= 1'b0;
      else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // directed words: data, count, last, digest length in force for the word
  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic [6:0]  len;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{64'h0, 4'd0, 1'b1, 7'd64},                 // empty message
    '{64'h0000000000636261, 4'd3, 1'b1, 7'd64},  // "abc"
    '{64'hffffffffffffffff, 4'd8, 1'b1, 7'd64},
    '{64'hffffffffffffffff, 4'd15, 1'b1, 7'd64}, // count above 8
    '{64'h0123456789abcdef, 4'd9, 1'b0, 7'd64},
    '{64'h0, 4'd0, 1'b1, 7'd64},                 // empty last word after data
    '{64'h0000000000636261, 4'd3, 1'b1, 7'd1},
    '{64'h0000000000636261, 4'd3, 1'b1, 7'd0},   // length 0 acts as 1
    '{64'h0000000000636261, 4'd3, 1'b1, 7'd127}, // above 64 acts as 64
    '{64'h8000000000000001, 4'd1, 1'b1, 7'd13},
    '{64'h0000000000636261, 4'd3, 1'b1, 7'd32}
  };

  logic [63:0] abc_first = 64'h0d4d1c983fa580ba;

  initial begin
    in_item_t it;
    wait_cycles(5);
    rst <= 1'b0;
    len_reg = LEN_RESET;
    for (int i = 0; i < 16; i++) wv[i] = '0;
    restart_hash();

    foreach (dir_tab[i]) begin
      if (dir_tab[i].len != len_reg) write_len(dir_tab[i].len);
      it.data_word = dir_tab[i].data;
      it.valid_bytes = dir_tab[i].cnt;
      it.is_last = dir_tab[i].last;
      if (i == 1) drain();
      send_word(it);
      if (i == 1 && digest_q[0].digest_word !== abc_first) begin
        errors++;
        $display("predictor abc digest wrong: %h", digest_q[0].digest_word);
      end
    end

    // exactly one full block, then one word past it
    send_message(16, 1'b0);
    send_message(17, 1'b0);
    write_len(7'd64);
    // mid-message register write discards the partial message
    send_message(3, 1'b0);
    it = '{64'h1122334455667788, 4'd8, 1'b0};
    send_word(it);
    write_len(7'd20);

    while (1) begin
      static int sent = 0;
      if (sent > 110) break;
      if ($urandom_range(0, 4) == 0) write_len(7'($urandom_range(0, 127)));
      burst_msg: begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 6);
        send_message(n, $urandom_range(0, 1));
        sent += n;
      end
      if (sent > 60 && sent < 70) drain();   // sender holds until all digests arrive
    end
    write_len(7'd64);
    quiet = 1'b1;
    for (int m = 0; m < 4; m++) send_message($urandom_range(1, 5), 1'b1);
    drain();
    wait_cycles(400);
    if (errors == 0 && digest_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
